>>> rtl/firq31_pkg.sv
// ----------------------------------------------------------------------------
// firq31_pkg
// Shared types and constants of the Q31 FIR filter with a wide accumulator.
// ----------------------------------------------------------------------------
package firq31_pkg;

  localparam int MAX_TAPS = 64;
  localparam int ADDR_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TAP_W    = $clog2(MAX_TAPS + 1);
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  // room for the sum of MAX_TAPS full products
  localparam int ACC_W    = PROD_W + ADDR_W;

  localparam int NUM_TAPS_W = 7;
  localparam int SHIFT_W    = 6;
  localparam int PADDR_W    = 3;

  // register index on the configuration port
  typedef enum logic {
    REG_NUM_TAPS = 1'b0,
    REG_SHIFT    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_PUSH    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

>>> rtl/fir_filter_q31_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_q31_unit
// Q31 FIR filter, forward-correlation order, with a wide accumulator.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake        payload
//  in       sink       in_valid/ready   in_command, in_coef_index, in_data_value
//  out      source     out_valid/ready  out_filtered_value
//  cfg      APB slave  psel/penable     num_taps (0x0), shift_amount (0x4)
//
//  load, restart and pushes that leave the window short complete as they are accepted
//  a push that yields a result runs through accept, a read phase over the n
//  effective taps on the single shared multiply-accumulate, and a drain of
//  the ram read and product registers
//  the result moves to an output register; the next input transfer is taken
//  while it waits, and the unit holds in its drain phase only if a second
//  result is ready before the first one is taken
//  synchronous active-low reset clears control state and loads config defaults
//
module fir_filter_q31_unit
  import firq31_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [5:0]               in_coef_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_filtered_value,
  // configuration port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [PADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FLUSH
  } state_t;

  state_t                   state_r, state_nxt;
  logic [NUM_TAPS_W-1:0]    num_taps_r, num_taps_nxt;
  logic [SHIFT_W-1:0]       shift_r, shift_nxt;
  logic [TAP_W-1:0]         held_r, held_nxt;
  logic [ADDR_W-1:0]        wp_r, wp_nxt;
  logic [ADDR_W-1:0]        sp_r, sp_nxt;
  logic [ADDR_W-1:0]        cp_r, cp_nxt;
  logic [TAP_W-1:0]         cnt_r, cnt_nxt;
  logic                     rd_v_r, rd_v_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_val_r, out_val_nxt;

  logic [TAP_W-1:0]         n_eff;
  logic [ADDR_W-1:0]        wp_inc;
  logic [ADDR_W-1:0]        sp_inc;
  logic [TAP_W:0]           start_sum;
  logic [ADDR_W-1:0]        start_ptr;
  logic                     coef_we;
  logic                     smp_we;
  logic [DATA_W-1:0]        coef_rd;
  logic [DATA_W-1:0]        smp_rd;
  mac_ctrl_t                mac_ctrl;
  logic                     mac_busy;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_shifted;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  // storage
  firq31_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (ADDR_W'(in_coef_index)),
    .wdata (in_data_value),
    .raddr (cp_r),
    .rdata (coef_rd)
  );

  // sample window kept as a circular buffer, wp_r points past the newest
  firq31_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TAPS)) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (wp_r),
    .wdata (in_data_value),
    .raddr (sp_r),
    .rdata (smp_rd)
  );

  firq31_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .sample (smp_rd),
    .coef   (coef_rd),
    .busy   (mac_busy),
    .acc    (acc)
  );

  // zero taps act as one, too many as the store depth
  always_comb begin
    if (num_taps_r == '0) begin
      n_eff = TAP_W'(1);
    end else if (num_taps_r > MAX_TAPS) begin
      n_eff = TAP_W'(MAX_TAPS);
    end else begin
      n_eff = TAP_W'(num_taps_r);
    end
  end

  assign wp_inc = (wp_r == ADDR_W'(MAX_TAPS - 1)) ? '0 : ADDR_W'(wp_r + 1'b1);
  assign sp_inc = (sp_r == ADDR_W'(MAX_TAPS - 1)) ? '0 : ADDR_W'(sp_r + 1'b1);

  // oldest of the last n samples, counted back from the slot after the newest
  assign start_sum = (TAP_W + 1)'(wp_inc) + (TAP_W + 1)'(MAX_TAPS) - (TAP_W + 1)'(n_eff);
  assign start_ptr = (start_sum >= (TAP_W + 1)'(MAX_TAPS))
                     ? ADDR_W'(start_sum - (TAP_W + 1)'(MAX_TAPS))
                     : ADDR_W'(start_sum);

  assign acc_shifted = acc >>> shift_r;

  // apb write decode
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    state_nxt     = state_r;
    num_taps_nxt  = num_taps_r;
    shift_nxt     = shift_r;
    held_nxt      = held_r;
    wp_nxt        = wp_r;
    sp_nxt        = sp_r;
    cp_nxt        = cp_r;
    cnt_nxt       = cnt_r;
    rd_v_nxt      = (state_r == S_READ);
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    coef_we       = 1'b0;
    smp_we        = 1'b0;
    mac_ctrl      = '0;
    mac_ctrl.valid = rd_v_r;

    if (cfg_wr) begin
      case (cfg_idx)
        REG_NUM_TAPS: num_taps_nxt = cfg_pwdata[NUM_TAPS_W-1:0];
        REG_SHIFT:    shift_nxt    = cfg_pwdata[SHIFT_W-1:0];
        default:      ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_LOAD: begin
              // out-of-range index is dropped
              coef_we = (in_coef_index < MAX_TAPS);
            end
            CMD_PUSH: begin
              smp_we   = 1'b1;
              wp_nxt   = wp_inc;
              held_nxt = (held_r < TAP_W'(MAX_TAPS)) ? TAP_W'(held_r + 1'b1) : held_r;
              // window full: run the correlation
              if (held_nxt >= n_eff) begin
                mac_ctrl.clear = 1'b1;
                sp_nxt         = start_ptr;
                cp_nxt         = '0;
                cnt_nxt        = n_eff;
                state_nxt      = S_READ;
              end
            end
            CMD_RESTART: begin
              held_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        // one tap per cycle into the shared mac
        sp_nxt  = sp_inc;
        cp_nxt  = ADDR_W'(cp_r + 1'b1);
        cnt_nxt = TAP_W'(cnt_r - 1'b1);
        if (cnt_r == TAP_W'(1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // wait for the last product to land, then for a free output slot
        if (!rd_v_r && !mac_busy && (!out_valid_r || out_ready)) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = acc_shifted[DATA_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_taps_r  <= NUM_TAPS_W'(1);
      shift_r     <= SHIFT_W'(31);
      held_r      <= '0;
      wp_r        <= '0;
      sp_r        <= '0;
      cp_r        <= '0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_val_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      num_taps_r  <= num_taps_nxt;
      shift_r     <= shift_nxt;
      held_r      <= held_nxt;
      wp_r        <= wp_nxt;
      sp_r        <= sp_nxt;
      cp_r        <= cp_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_val_r   <= out_val_nxt;
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_val_r;
  assign cfg_pready         = 1'b1;

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_NUM_TAPS: cfg_prdata = 32'(num_taps_r);
      REG_SHIFT:    cfg_prdata = 32'(shift_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // checks
  // the read pipeline only runs while a correlation is in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r != S_IDLE))
    else $error("sample read in flight while idle");

  // tap counter never runs dry inside the read phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (cnt_r != '0))
    else $error("read phase with zero taps left");

  // a new result only comes out of the drain phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ready) && out_valid_nxt |-> (state_r == S_FLUSH))
    else $error("result loaded outside drain phase");

  // sample count saturates at the store depth
  assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= TAP_W'(MAX_TAPS))
    else $error("sample count beyond window depth");

endmodule

>>> rtl/firq31_ram.sv
// ----------------------------------------------------------------------------
// firq31_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module firq31_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/firq31_mac.sv
// ----------------------------------------------------------------------------
// firq31_mac
// Shared multiply-accumulate unit: registered 32x32 product, then wide add.
// ----------------------------------------------------------------------------
module firq31_mac
  import firq31_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] sample,
  input  logic signed [DATA_W-1:0] coef,
  output logic                     busy,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      prod_r   <= '0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= ctrl.valid;
      if (ctrl.valid) begin
        prod_r <= sample * coef;
      end
      if (ctrl.clear) begin
        acc_r <= '0;
      end else if (prod_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign busy = prod_v_r;
  assign acc  = acc_r;

endmodule
